// ===== sv/cbc_pkg.sv =====
// shared types, codes and defaults of the cartridge bank controller
package cbc_pkg;

    // controller kinds
    localparam logic [2:0] CART_MBC1   = 3'd0;
    localparam logic [2:0] CART_MBC2   = 3'd1;
    localparam logic [2:0] CART_MBC3   = 3'd2;
    localparam logic [2:0] CART_MBC5   = 3'd3;
    localparam logic [2:0] CART_RUMBLE = 3'd4;
    localparam logic [2:0] CART_HUC1   = 3'd5;
    localparam logic [2:0] CART_HUC3   = 3'd6;

    // result regions
    localparam logic [2:0] REGION_ROM     = 3'd0;
    localparam logic [2:0] REGION_RAM     = 3'd1;
    localparam logic [2:0] REGION_CLOCK   = 3'd2;
    localparam logic [2:0] REGION_FIXED   = 3'd3;
    localparam logic [2:0] REGION_CONTROL = 3'd4;
    localparam logic [2:0] REGION_OUTSIDE = 3'd5;

    // configuration register indexes
    localparam logic [1:0] REG_CART_TYPE      = 2'd0;
    localparam logic [1:0] REG_ROM_BANK_COUNT = 2'd1;
    localparam logic [1:0] REG_RAM_BANK_COUNT = 2'd2;

    // access kinds
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // register reset values
    localparam logic [2:0] CART_TYPE_RESET      = CART_MBC1;
    localparam logic [9:0] ROM_BANK_COUNT_RESET = 10'd2;
    localparam logic [4:0] RAM_BANK_COUNT_RESET = 5'd1;

    // fixed read values and enable key
    localparam logic [7:0] FIXED_HUC3    = 8'h01;
    localparam logic [7:0] FIXED_DEFAULT = 8'hFF;
    localparam logic [3:0] ENABLE_KEY    = 4'hA;

    // parameter defaults
    localparam int MAX_ROM_BANKS_DEFAULT = 512;
    localparam int MAX_RAM_BANKS_DEFAULT = 16;

    typedef struct packed {
        logic        operation;
        logic [15:0] address;
        logic [7:0]  data;
    } t_cmd;

    typedef struct packed {
        logic [2:0]  region;
        logic [22:0] rom_address;
        logic [16:0] ram_address;
        logic [2:0]  clock_index;
        logic [7:0]  fixed_value;
        logic        latch_strobe;
        logic        clock_write_strobe;
        logic [7:0]  strobe_data;
        logic [8:0]  current_rom_bank;
        logic [3:0]  current_ram_bank;
        logic        ram_enabled;
    } t_rsp;

    typedef struct packed {
        logic [1:0] index;
        logic [9:0] value;
    } t_cfg_wr;

    typedef struct packed {
        logic [2:0] cart_type;
        logic [9:0] rom_bank_count;
        logic [4:0] ram_bank_count;
    } t_bank_cfg;

    typedef struct packed {
        logic [8:0] rom_bank;
        logic [3:0] ram_bank;
        logic       ram_enable;
        logic       banking_mode;
        logic [3:0] clock_select;
    } t_bank_state;

endpackage

// ===== sv/cbc_stream_if.sv =====
// valid/ready channel carrying one payload per transaction
interface cbc_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== sv/cartridge_bank_controller.sv =====
// top level of the cartridge bank controller: channels, registers and bank state
// One bus access per transaction on i_cmd, one result per access on o_rsp, in order.
// An access is taken into an input register, decoded in a single pass and written to
// the result register when that register is free, so its result reaches o_rsp through
// both registers; a new access can be taken every cycle while o_rsp takes results. The
// bank state is updated at the same edge the result is registered, so each access sees
// the banks left by the one before. While a finished result waits on o_rsp the input
// register can take one more access; i_cmd.ready then stays low until the result is taken.
// Configuration writes on i_cfg (index 0 controller kind, 1 rom bank count,
// 2 ram bank count) are always ready and take effect at once; write them only while
// no access is in flight. Bank counts act as masks and are applied on control writes.
module cartridge_bank_controller #(
    parameter int MAX_ROM_BANKS = cbc_pkg::MAX_ROM_BANKS_DEFAULT,
    parameter int MAX_RAM_BANKS = cbc_pkg::MAX_RAM_BANKS_DEFAULT
) (
    input logic         i_clk,
    input logic         i_rst_n,
    cbc_stream_if.sink  i_cmd,
    cbc_stream_if.source o_rsp,
    cbc_stream_if.sink  i_cfg
);
    localparam logic [8:0] ROM_LIMIT = 9'(MAX_ROM_BANKS - 1);

    // configuration registers
    cbc_pkg::t_bank_cfg   r_cfg;
    cbc_pkg::t_cfg_wr     cfg_wr;

    // bank state
    cbc_pkg::t_bank_state r_state;
    cbc_pkg::t_bank_state n_state;

    // input and result registers
    logic                 r_in_valid;
    cbc_pkg::t_cmd        r_in;
    logic                 r_out_valid;
    cbc_pkg::t_rsp        r_out;
    cbc_pkg::t_rsp        n_out;

    logic                 out_free;
    logic                 advance;
    logic                 take_in;

    assign cfg_wr      = i_cfg.payload;
    assign i_cfg.ready = 1'b1;

    // result register frees when empty or being taken this cycle
    assign out_free    = !r_out_valid || o_rsp.ready;
    assign advance     = r_in_valid && out_free;
    assign i_cmd.ready = !r_in_valid || out_free;
    assign take_in     = i_cmd.valid && i_cmd.ready;

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;

    cbc_decode #(
        .MAX_ROM_BANKS (MAX_ROM_BANKS),
        .MAX_RAM_BANKS (MAX_RAM_BANKS)
    ) u_decode (
        .i_cfg   (r_cfg),
        .i_state (r_state),
        .i_cmd   (r_in),
        .o_state (n_state),
        .o_rsp   (n_out)
    );

    // configuration writes; indexes beyond the list are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cart_type      <= cbc_pkg::CART_TYPE_RESET;
            r_cfg.rom_bank_count <= cbc_pkg::ROM_BANK_COUNT_RESET;
            r_cfg.ram_bank_count <= cbc_pkg::RAM_BANK_COUNT_RESET;
        end else if (i_cfg.valid) begin
            unique case (cfg_wr.index)
                cbc_pkg::REG_CART_TYPE:      r_cfg.cart_type      <= cfg_wr.value[2:0];
                cbc_pkg::REG_ROM_BANK_COUNT: r_cfg.rom_bank_count <= cfg_wr.value;
                cbc_pkg::REG_RAM_BANK_COUNT: r_cfg.ram_bank_count <= cfg_wr.value[4:0];
                default: ;
            endcase
        end
    end

    // bank state moves with each access that reaches the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            // rom bank one, masked with the largest rom bank index
            r_state.rom_bank     <= 9'd1 & ROM_LIMIT;
            r_state.ram_bank     <= 4'd0;
            r_state.ram_enable   <= 1'b0;
            r_state.banking_mode <= 1'b0;
            r_state.clock_select <= 4'd0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // handshake control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (take_in) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_in <= i_cmd.payload;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end
endmodule

// ===== sv/cbc_decode.sv =====
// access decode: next bank state and result for one bus access
module cbc_decode #(
    parameter int MAX_ROM_BANKS = cbc_pkg::MAX_ROM_BANKS_DEFAULT,
    parameter int MAX_RAM_BANKS = cbc_pkg::MAX_RAM_BANKS_DEFAULT
) (
    input  cbc_pkg::t_bank_cfg   i_cfg,
    input  cbc_pkg::t_bank_state i_state,
    input  cbc_pkg::t_cmd        i_cmd,
    output cbc_pkg::t_bank_state o_state,
    output cbc_pkg::t_rsp        o_rsp
);
    localparam logic [8:0] ROM_LIMIT = 9'(MAX_ROM_BANKS - 1);
    localparam logic [3:0] RAM_LIMIT = 4'(MAX_RAM_BANKS - 1);

    logic [15:0] a;
    logic [7:0]  b;
    logic [3:0]  ha;
    logic        wr;
    logic [9:0]  rom_cnt_m1;
    logic [4:0]  ram_cnt_m1;
    logic [8:0]  rom_mask;
    logic [3:0]  ram_mask;
    logic [6:0]  b7;
    cbc_pkg::t_bank_state s;

    assign a  = i_cmd.address;
    assign b  = i_cmd.data;
    assign ha = a[15:12];
    assign wr = (i_cmd.operation == cbc_pkg::OP_WRITE);
    assign b7 = b[6:0];

    assign rom_cnt_m1 = i_cfg.rom_bank_count - 10'd1;
    assign ram_cnt_m1 = i_cfg.ram_bank_count - 5'd1;
    assign rom_mask   = rom_cnt_m1[8:0] & ROM_LIMIT;
    assign ram_mask   = ram_cnt_m1[3:0] & RAM_LIMIT;

    always_comb begin
        s     = i_state;
        o_rsp = '0;
        o_rsp.region = cbc_pkg::REGION_OUTSIDE;

        if (!a[15]) begin
            if (wr) begin
                o_rsp.region = cbc_pkg::REGION_CONTROL;
                unique case (i_cfg.cart_type)
                    cbc_pkg::CART_MBC1, cbc_pkg::CART_HUC1: begin
                        unique case (a[14:13])
                            2'd0: s.ram_enable = (b[3:0] == cbc_pkg::ENABLE_KEY);
                            2'd1: s.rom_bank = {2'b00, i_state.rom_bank[6:5],
                                               (b[4:0] == 5'd0) ? 5'd1 : b[4:0]};
                            2'd2: begin
                                if (i_state.banking_mode) begin
                                    s.ram_bank = {2'b00, b[1:0]};
                                end else begin
                                    s.rom_bank = {2'b00, b[1:0], i_state.rom_bank[4:0]};
                                end
                            end
                            default: s.banking_mode = b[0];
                        endcase
                    end
                    cbc_pkg::CART_MBC2: begin
                        if (!a[14]) begin
                            if (!a[8]) begin
                                s.ram_enable = (b[3:0] == cbc_pkg::ENABLE_KEY);
                            end else begin
                                s.rom_bank = (b[3:0] == 4'd0) ? 9'd1 : {5'd0, b[3:0]};
                            end
                        end
                    end
                    cbc_pkg::CART_MBC3, cbc_pkg::CART_HUC3: begin
                        unique case (a[14:13])
                            2'd0: s.ram_enable = (b[3:0] == cbc_pkg::ENABLE_KEY);
                            2'd1: s.rom_bank = (b7 == 7'd0) ? 9'd1 : {2'b00, b7};
                            2'd2: begin
                                s.clock_select = b[3:0];
                                s.ram_bank     = {2'b00, b[1:0]};
                            end
                            default: begin
                                o_rsp.latch_strobe = 1'b1;
                                o_rsp.strobe_data  = b;
                            end
                        endcase
                    end
                    cbc_pkg::CART_MBC5, cbc_pkg::CART_RUMBLE: begin
                        unique case (ha[2:0])
                            3'd0, 3'd1: s.ram_enable = (b[3:0] == cbc_pkg::ENABLE_KEY);
                            3'd2: s.rom_bank = {i_state.rom_bank[8], b};
                            3'd3: s.rom_bank = {b[0], i_state.rom_bank[7:0]};
                            3'd4, 3'd5: begin
                                // rumble: bit 3 drives the motor, not the bank
                                s.ram_bank = (i_cfg.cart_type == cbc_pkg::CART_RUMBLE) ?
                                             {1'b0, b[2:0]} : b[3:0];
                            end
                            default: ;
                        endcase
                    end
                    default: ;
                endcase
                s.rom_bank = s.rom_bank & rom_mask;
                s.ram_bank = s.ram_bank & ram_mask;
            end else begin
                o_rsp.region      = cbc_pkg::REGION_ROM;
                o_rsp.rom_address = a[14] ? {i_state.rom_bank, a[13:0]} : {9'd0, a[13:0]};
            end
        end else if (a[15:13] == 3'b101) begin
            if (!i_state.ram_enable) begin
                if (wr) begin
                    o_rsp.region = cbc_pkg::REGION_CONTROL;
                end else begin
                    o_rsp.region      = cbc_pkg::REGION_FIXED;
                    o_rsp.fixed_value = (i_cfg.cart_type == cbc_pkg::CART_HUC3) ?
                                        cbc_pkg::FIXED_HUC3 : cbc_pkg::FIXED_DEFAULT;
                end
            end else if (i_state.clock_select[3]) begin
                o_rsp.region      = cbc_pkg::REGION_CLOCK;
                o_rsp.clock_index = i_state.clock_select[2:0];
                if (wr) begin
                    o_rsp.clock_write_strobe = 1'b1;
                    o_rsp.strobe_data        = b;
                end
            end else begin
                o_rsp.region      = cbc_pkg::REGION_RAM;
                o_rsp.ram_address = {i_state.ram_bank, a[12:0]};
            end
        end

        o_rsp.current_rom_bank = s.rom_bank;
        o_rsp.current_ram_bank = s.ram_bank;
        o_rsp.ram_enabled      = s.ram_enable;
        o_state                = s;
    end
endmodule

// ===== test/cartridge_bank_controller_test.sv =====
// self-checking testbench for the cartridge bank controller: directed table, then random phases
module cartridge_bank_controller_test;
    timeunit 1ns;
    timeprecision 1ps;

    // controller kind code with no decoder behind it
    localparam logic [2:0] CART_UNKNOWN = 3'd7;

    localparam int RESET_CYCLES    = 5;
    localparam int PIPE_LATENCY    = 2;     // settling wait after the last result, in cycles
    localparam int STALL_LIMIT     = 2000;  // cycles with no transaction at all
    localparam int HOLD_CYCLES     = 300;   // long receiver hold-off
    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 96;
    localparam int HOLD_PHASE      = 9;

    typedef struct {
        bit            is_config;
        logic [1:0]    reg_index;
        logic [9:0]    reg_value;
        cbc_pkg::t_cmd access;
        bit            typed;
        cbc_pkg::t_rsp want;
    } t_directed_step;

    logic clk = 1'b0;
    logic rst_n;

    cbc_stream_if #(.T(cbc_pkg::t_cmd))    cmd_ch ();
    cbc_stream_if #(.T(cbc_pkg::t_rsp))    rsp_ch ();
    cbc_stream_if #(.T(cbc_pkg::t_cfg_wr)) cfg_ch ();

    cartridge_bank_controller uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cmd   (cmd_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    // 10 ns clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // bank model: configuration copy
    logic [2:0] cart_kind;
    logic [9:0] rom_count;
    logic [4:0] ram_count;

    // bank model: controller state
    logic [8:0] rom_bank;
    logic [3:0] ram_bank;
    logic       ram_en;
    logic       bank_mode;
    logic [3:0] clk_sel;

    cbc_pkg::t_rsp pending_results [$];
    t_directed_step directed [$];

    int  mismatches = 0;
    int  idle_cycles = 0;
    int  send_gap_pct = 24;
    int  recv_stall_pct = 60;
    bit  hold_request = 1'b0;

    // per-phase controller kind and bank counts; extremes, zero and odd counts included
    cbc_pkg::t_bank_cfg phase_setup [PHASES] = '{
        '{cbc_pkg::CART_MBC1,   10'd512, 5'd16},
        '{cbc_pkg::CART_MBC2,   10'd16,  5'd1},
        '{cbc_pkg::CART_MBC3,   10'd128, 5'd4},
        '{cbc_pkg::CART_MBC5,   10'd512, 5'd16},
        '{cbc_pkg::CART_RUMBLE, 10'd64,  5'd16},
        '{cbc_pkg::CART_HUC1,   10'd2,   5'd2},
        '{cbc_pkg::CART_HUC3,   10'd256, 5'd4},
        '{CART_UNKNOWN,         10'd32,  5'd8},
        '{cbc_pkg::CART_MBC5,   10'd0,   5'd0},
        '{cbc_pkg::CART_MBC1,   10'd3,   5'd5},
        '{cbc_pkg::CART_MBC3,   10'd512, 5'd16},
        '{cbc_pkg::CART_HUC3,   10'd8,   5'd1}
    };

    // ------------------------------------------------------------------
    // bank model
    // ------------------------------------------------------------------

    // counts act as masks; zero wraps to all ones, odd counts drop bits
    function automatic void apply_bank_masks();
        logic [9:0] rom_mask;
        logic [4:0] ram_mask;
        rom_mask = rom_count - 10'd1;
        ram_mask = ram_count - 5'd1;
        rom_bank &= rom_mask[8:0];
        ram_bank &= ram_mask[3:0];
    endfunction

    function automatic void reset_bank_model();
        cart_kind = cbc_pkg::CART_TYPE_RESET;
        rom_count = cbc_pkg::ROM_BANK_COUNT_RESET;
        ram_count = cbc_pkg::RAM_BANK_COUNT_RESET;
        rom_bank  = 9'd1;
        ram_bank  = 4'd0;
        ram_en    = 1'b0;
        bank_mode = 1'b0;
        clk_sel   = 4'd0;
        apply_bank_masks();
    endfunction

    function automatic void apply_register(input logic [1:0] idx, input logic [9:0] val);
        case (idx)
            cbc_pkg::REG_CART_TYPE:      cart_kind = val[2:0];
            cbc_pkg::REG_ROM_BANK_COUNT: rom_count = val;
            cbc_pkg::REG_RAM_BANK_COUNT: ram_count = val[4:0];
            default: ;
        endcase
    endfunction

    function automatic void decode_mbc5(input logic [3:0] hi, input logic [7:0] b);
        case (hi)
            4'h0, 4'h1: ram_en = (b[3:0] == cbc_pkg::ENABLE_KEY);
            4'h2:       rom_bank = {rom_bank[8], b};
            4'h3:       rom_bank = {b[0], rom_bank[7:0]};
            4'h4, 4'h5: ram_bank = b[3:0];
            default: ;
        endcase
    endfunction

    // one bus access: updates the bank state and returns the result it produces
    function automatic cbc_pkg::t_rsp predict_access(input cbc_pkg::t_cmd c);
        cbc_pkg::t_rsp r;
        logic [3:0]    hi;
        logic [7:0]    b;
        r  = '0;
        b  = c.data;
        hi = c.address[15:12];
        if (c.address < 16'h8000) begin
            if (c.operation == cbc_pkg::OP_WRITE) begin
                r.region = cbc_pkg::REGION_CONTROL;
                case (cart_kind)
                    cbc_pkg::CART_MBC1, cbc_pkg::CART_HUC1: begin
                        case (c.address[14:13])
                            2'd0: ram_en = (b[3:0] == cbc_pkg::ENABLE_KEY);
                            2'd1: rom_bank = {2'b00, rom_bank[6:5],
                                              (b[4:0] == 5'd0) ? 5'd1 : b[4:0]};
                            2'd2: begin
                                if (bank_mode)
                                    ram_bank = {2'b00, b[1:0]};
                                else
                                    rom_bank = {2'b00, b[1:0], rom_bank[4:0]};
                            end
                            default: bank_mode = b[0];
                        endcase
                    end
                    cbc_pkg::CART_MBC2: begin
                        // only the lower half decodes, address bit 8 picks the register
                        if (c.address < 16'h4000) begin
                            if (!c.address[8])
                                ram_en = (b[3:0] == cbc_pkg::ENABLE_KEY);
                            else
                                rom_bank = (b[3:0] == 4'd0) ? 9'd1 : {5'd0, b[3:0]};
                        end
                    end
                    cbc_pkg::CART_MBC3, cbc_pkg::CART_HUC3: begin
                        case (c.address[14:13])
                            2'd0: ram_en = (b[3:0] == cbc_pkg::ENABLE_KEY);
                            2'd1: rom_bank = (b[6:0] == 7'd0) ? 9'd1 : {2'b00, b[6:0]};
                            2'd2: begin
                                clk_sel  = b[3:0];
                                ram_bank = {2'b00, b[1:0]};
                            end
                            default: begin
                                r.latch_strobe = 1'b1;
                                r.strobe_data  = b;
                            end
                        endcase
                    end
                    cbc_pkg::CART_RUMBLE: begin
                        // bit 3 of the ram bank byte drives the motor
                        if (hi == 4'h4 || hi == 4'h5)
                            b[3] = 1'b0;
                        decode_mbc5(hi, b);
                    end
                    cbc_pkg::CART_MBC5: decode_mbc5(hi, b);
                    default: ;
                endcase
                apply_bank_masks();
            end else begin
                r.region = cbc_pkg::REGION_ROM;
                if (c.address < 16'h4000)
                    r.rom_address = {9'd0, c.address[13:0]};
                else
                    r.rom_address = {rom_bank, c.address[13:0]};
            end
        end else if (c.address[15:13] == 3'b101) begin
            if (!ram_en) begin
                if (c.operation == cbc_pkg::OP_WRITE) begin
                    r.region = cbc_pkg::REGION_CONTROL;
                end else begin
                    r.region      = cbc_pkg::REGION_FIXED;
                    r.fixed_value = (cart_kind == cbc_pkg::CART_HUC3) ?
                                    cbc_pkg::FIXED_HUC3 : cbc_pkg::FIXED_DEFAULT;
                end
            end else if (clk_sel[3]) begin
                r.region      = cbc_pkg::REGION_CLOCK;
                r.clock_index = clk_sel[2:0];
                if (c.operation == cbc_pkg::OP_WRITE) begin
                    r.clock_write_strobe = 1'b1;
                    r.strobe_data        = b;
                end
            end else begin
                r.region      = cbc_pkg::REGION_RAM;
                r.ram_address = {ram_bank, c.address[12:0]};
            end
        end else begin
            r.region = cbc_pkg::REGION_OUTSIDE;
        end
        r.current_rom_bank = rom_bank;
        r.current_ram_bank = ram_bank;
        r.ram_enabled      = ram_en;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // result with only the fields that plain reads and dropped writes fill in
    function automatic cbc_pkg::t_rsp status_only(input logic [2:0] region,
                                                  input logic [22:0] rom_a,
                                                  input logic [7:0] fixed,
                                                  input logic [8:0] bank,
                                                  input logic enabled);
        cbc_pkg::t_rsp r;
        r                  = '0;
        r.region           = region;
        r.rom_address      = rom_a;
        r.fixed_value      = fixed;
        r.current_rom_bank = bank;
        r.ram_enabled      = enabled;
        return r;
    endfunction

    function automatic void add_access(input logic op, input logic [15:0] addr,
                                       input logic [7:0] data);
        t_directed_step s;
        s = '{default: '0};
        s.access = '{op, addr, data};
        directed.push_back(s);
    endfunction

    function automatic void add_typed(input logic op, input logic [15:0] addr,
                                      input logic [7:0] data, input cbc_pkg::t_rsp want);
        t_directed_step s;
        s = '{default: '0};
        s.access = '{op, addr, data};
        s.typed  = 1'b1;
        s.want   = want;
        directed.push_back(s);
    endfunction

    function automatic void add_config(input logic [1:0] idx, input logic [9:0] val);
        t_directed_step s;
        s = '{default: '0};
        s.is_config = 1'b1;
        s.reg_index = idx;
        s.reg_value = val;
        directed.push_back(s);
    endfunction

    // mostly control writes and ram-space traffic, the rest rom reads and noise
    function automatic cbc_pkg::t_cmd random_access();
        cbc_pkg::t_cmd c;
        int            pick;
        pick   = int'($urandom_range(99));
        c.data = 8'($urandom_range(255));
        if (pick < 40) begin
            c.operation = cbc_pkg::OP_WRITE;
            c.address   = 16'($urandom_range(16'h7FFF));
            // bias enable writes toward the unlock key so ram space opens up
            if (c.address[14:13] == 2'd0 && $urandom_range(1) == 1)
                c.data[3:0] = cbc_pkg::ENABLE_KEY;
        end else if (pick < 70) begin
            c.operation      = 1'($urandom_range(1));
            c.address[15:13] = 3'b101;
            c.address[12:0]  = 13'($urandom_range(16'h1FFF));
        end else if (pick < 85) begin
            c.operation = cbc_pkg::OP_READ;
            c.address   = 16'($urandom_range(16'h7FFF));
        end else begin
            c.operation = 1'($urandom_range(1));
            c.address   = 16'($urandom_range(16'hFFFF));
        end
        return c;
    endfunction

    // entered and left at a falling edge; valid stays high for a following transaction
    task automatic send_access(input cbc_pkg::t_cmd access, input bit typed,
                               input cbc_pkg::t_rsp want);
        cbc_pkg::t_rsp predicted;
        cfg_ch.valid <= 1'b0;
        while ($urandom_range(99) < send_gap_pct) begin
            cmd_ch.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_ch.valid   <= 1'b1;
        cmd_ch.payload <= access;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        predicted = predict_access(access);
        pending_results.push_back(typed ? want : predicted);
        @(negedge clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [9:0] val);
        cfg_ch.valid   <= 1'b1;
        cfg_ch.payload <= '{idx, val};
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        apply_register(idx, val);
        @(negedge clk);
    endtask

    // sender pauses until every result is back and the pipeline is quiet
    task automatic wait_for_results();
        cmd_ch.valid <= 1'b0;
        cfg_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (PIPE_LATENCY) @(negedge clk);
    endtask

    task automatic check_result(input cbc_pkg::t_rsp got, input cbc_pkg::t_rsp want);
        if (got.region !== want.region) begin
            $error("region: expected %0d, got %0d", want.region, got.region);
            mismatches++;
        end
        if (got.rom_address !== want.rom_address) begin
            $error("rom_address: expected %h, got %h", want.rom_address, got.rom_address);
            mismatches++;
        end
        if (got.ram_address !== want.ram_address) begin
            $error("ram_address: expected %h, got %h", want.ram_address, got.ram_address);
            mismatches++;
        end
        if (got.clock_index !== want.clock_index) begin
            $error("clock_index: expected %0d, got %0d", want.clock_index, got.clock_index);
            mismatches++;
        end
        if (got.fixed_value !== want.fixed_value) begin
            $error("fixed_value: expected %h, got %h", want.fixed_value, got.fixed_value);
            mismatches++;
        end
        if (got.latch_strobe !== want.latch_strobe) begin
            $error("latch_strobe: expected %b, got %b", want.latch_strobe, got.latch_strobe);
            mismatches++;
        end
        if (got.clock_write_strobe !== want.clock_write_strobe) begin
            $error("clock_write_strobe: expected %b, got %b",
                   want.clock_write_strobe, got.clock_write_strobe);
            mismatches++;
        end
        if (got.strobe_data !== want.strobe_data) begin
            $error("strobe_data: expected %h, got %h", want.strobe_data, got.strobe_data);
            mismatches++;
        end
        if (got.current_rom_bank !== want.current_rom_bank) begin
            $error("current_rom_bank: expected %h, got %h",
                   want.current_rom_bank, got.current_rom_bank);
            mismatches++;
        end
        if (got.current_ram_bank !== want.current_ram_bank) begin
            $error("current_ram_bank: expected %h, got %h",
                   want.current_ram_bank, got.current_ram_bank);
            mismatches++;
        end
        if (got.ram_enabled !== want.ram_enabled) begin
            $error("ram_enabled: expected %b, got %b", want.ram_enabled, got.ram_enabled);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------
    // result side: ready generation, checking, watchdog
    // ------------------------------------------------------------------

    // ready changes on the falling edge; one long hold-off when asked
    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_request) begin
                hold_request = 1'b0;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end else begin
                rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // every result transaction is matched against the oldest prediction
    always @(posedge clk) begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_results.size() == 0) begin
                $error("result transaction with no access outstanding");
                mismatches++;
            end else begin
                check_result(rsp_ch.payload, pending_results.pop_front());
            end
        end
    end

    // ends the run if no transaction moves on any channel for too long
    always @(posedge clk) begin
        if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("cartridge_bank_controller regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial begin
        rst_n          = 1'b0;
        cmd_ch.valid   = 1'b0;
        cmd_ch.payload = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.payload = '0;

        // directed table; typed rows carry results readable at a glance
        // after reset: bank 1, ram disabled, mbc1
        add_typed(cbc_pkg::OP_READ,  16'h0000, 8'h00,
                  status_only(cbc_pkg::REGION_ROM, 23'h0, 8'h00, 9'd1, 1'b0));
        add_typed(cbc_pkg::OP_READ,  16'h7FFF, 8'h00,
                  status_only(cbc_pkg::REGION_ROM, 23'h7FFF, 8'h00, 9'd1, 1'b0));
        add_typed(cbc_pkg::OP_READ,  16'hA000, 8'h00,
                  status_only(cbc_pkg::REGION_FIXED, 23'h0, cbc_pkg::FIXED_DEFAULT,
                              9'd1, 1'b0));
        add_typed(cbc_pkg::OP_WRITE, 16'hBFFF, 8'h55,
                  status_only(cbc_pkg::REGION_CONTROL, 23'h0, 8'h00, 9'd1, 1'b0));
        add_typed(cbc_pkg::OP_READ,  16'hFFFF, 8'hFF,
                  status_only(cbc_pkg::REGION_OUTSIDE, 23'h0, 8'h00, 9'd1, 1'b0));
        // widest banks; a count change leaves the stored bank alone
        add_config(cbc_pkg::REG_ROM_BANK_COUNT, 10'd512);
        add_config(cbc_pkg::REG_RAM_BANK_COUNT, 10'd16);
        add_typed(cbc_pkg::OP_WRITE, 16'h0000, 8'h0A,
                  status_only(cbc_pkg::REGION_CONTROL, 23'h0, 8'h00, 9'd1, 1'b1));
        // mbc1: zero bank turns into one, upper bits, banking mode, ram bank
        add_access(cbc_pkg::OP_WRITE, 16'h2000, 8'h00);
        add_access(cbc_pkg::OP_WRITE, 16'h3FFF, 8'hFF);
        add_access(cbc_pkg::OP_WRITE, 16'h4000, 8'h03);
        add_access(cbc_pkg::OP_READ,  16'h4000, 8'h00);
        add_access(cbc_pkg::OP_WRITE, 16'h6000, 8'h01);
        add_access(cbc_pkg::OP_WRITE, 16'h5FFF, 8'hFF);
        add_access(cbc_pkg::OP_WRITE, 16'hBFFF, 8'hAA);
        // mbc2: address bit 8 selects the rom bank register
        add_config(cbc_pkg::REG_CART_TYPE, {7'd0, cbc_pkg::CART_MBC2});
        add_access(cbc_pkg::OP_WRITE, 16'h0100, 8'h00);
        add_access(cbc_pkg::OP_WRITE, 16'h3FFF, 8'hFF);
        // mbc3: clock select with bit 3 maps ram space to a clock register, then latch
        add_config(cbc_pkg::REG_CART_TYPE, {7'd0, cbc_pkg::CART_MBC3});
        add_access(cbc_pkg::OP_WRITE, 16'h4000, 8'h0B);
        add_access(cbc_pkg::OP_WRITE, 16'hA123, 8'h77);
        add_access(cbc_pkg::OP_WRITE, 16'h6000, 8'h01);
        add_access(cbc_pkg::OP_WRITE, 16'h2000, 8'h80);
        // huc3: disabled ram reads back its own fixed value
        add_config(cbc_pkg::REG_CART_TYPE, {7'd0, cbc_pkg::CART_HUC3});
        add_access(cbc_pkg::OP_WRITE, 16'h0000, 8'h00);
        add_access(cbc_pkg::OP_READ,  16'hA000, 8'h00);
        // rumble with an odd rom count and a zero ram count; motor bit dropped
        add_config(cbc_pkg::REG_CART_TYPE, {7'd0, cbc_pkg::CART_RUMBLE});
        add_config(cbc_pkg::REG_ROM_BANK_COUNT, 10'd3);
        add_config(cbc_pkg::REG_RAM_BANK_COUNT, 10'd0);
        add_access(cbc_pkg::OP_WRITE, 16'h4000, 8'hFF);
        add_access(cbc_pkg::OP_WRITE, 16'h7000, 8'hFF);
        // mbc5 with a zero rom count reaches the ninth bank bit
        add_config(cbc_pkg::REG_CART_TYPE, {7'd0, cbc_pkg::CART_MBC5});
        add_config(cbc_pkg::REG_ROM_BANK_COUNT, 10'd0);
        add_access(cbc_pkg::OP_WRITE, 16'h2000, 8'hFF);
        add_access(cbc_pkg::OP_WRITE, 16'h3000, 8'h01);
        // unknown kind: control writes only mask
        add_config(cbc_pkg::REG_CART_TYPE, {7'd0, CART_UNKNOWN});
        add_access(cbc_pkg::OP_WRITE, 16'h2000, 8'h12);

        // synchronous reset, released at a falling edge
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        reset_bank_model();
        @(negedge clk);

        foreach (directed[i]) begin
            if (directed[i].is_config) begin
                wait_for_results();
                write_register(directed[i].reg_index, directed[i].reg_value);
            end else begin
                send_access(directed[i].access, directed[i].typed, directed[i].want);
            end
        end

        // random phases: receiver stalls first, then sender gaps, then full rate
        for (int p = 0; p < PHASES; p++) begin
            wait_for_results();
            if (p == 4) begin
                send_gap_pct   = 60;
                recv_stall_pct = 24;
            end else if (p == 8) begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end
            write_register(cbc_pkg::REG_CART_TYPE, {7'd0, phase_setup[p].cart_type});
            write_register(cbc_pkg::REG_ROM_BANK_COUNT, phase_setup[p].rom_bank_count);
            write_register(cbc_pkg::REG_RAM_BANK_COUNT,
                           {5'd0, phase_setup[p].ram_bank_count});
            // the receiver holds off while accesses keep coming, so the block backs up
            if (p == HOLD_PHASE)
                hold_request = 1'b1;
            repeat (ITEMS_PER_PHASE)
                send_access(random_access(), 1'b0, '0);
        end

        wait_for_results();
        if (pending_results.size() != 0)
            mismatches++;
        if (mismatches == 0)
            $display("cartridge_bank_controller regression: pass");
        else
            $display("cartridge_bank_controller regression: fail");
        $finish;
    end

endmodule
